### sv/wpt_pkg.sv
// wpt_pkg: shared types, codes and sizes for the waveform pattern trigger
// used by every module of the block; depends on nothing
package wpt_pkg;

  localparam int LANE_WIDTH   = 16;
  localparam int TIME_WIDTH   = 32;
  localparam int COUNT_WIDTH  = 16;
  localparam int KIND_WIDTH   = 3;
  localparam int MAX_LANES    = 4;
  localparam int REP_WIDTH    = 5;
  localparam int DEF_NUM_LANES  = 4;
  localparam int DEF_MAX_REPEAT = 16;
  localparam int OUTQ_DEPTH   = 4;
  localparam int ADDR_WIDTH   = 6;
  localparam int DATA_WIDTH   = 64;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_DONTCARE = 3'd0,
    KIND_HIGH     = 3'd1,
    KIND_LOW      = 3'd2,
    KIND_VALUE    = 3'd3,
    KIND_RISE     = 3'd4,
    KIND_FALL     = 3'd5,
    KIND_ANYEDGE  = 3'd6
  } lane_kind_e;

  typedef enum logic [1:0] {
    MODE_COLLECT  = 2'd0,
    MODE_FORWARD  = 2'd1,
    MODE_BACKWARD = 2'd2
  } search_mode_e;

  typedef enum logic [2:0] {
    REG_LANE_KINDS   = 3'd0,
    REG_LANE_ENABLE  = 3'd1,
    REG_LANE_VALUES  = 3'd2,
    REG_WIN_START    = 3'd3,
    REG_WIN_END      = 3'd4,
    REG_MATCH_LIMIT  = 3'd5,
    REG_SEARCH_MODE  = 3'd6,
    REG_REPEAT_COUNT = 3'd7
  } reg_index_e;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]  win_start;
    logic [TIME_WIDTH-1:0]  win_end;
    logic [COUNT_WIDTH-1:0] match_limit;
    logic [1:0]             mode;
    logic [REP_WIDTH-1:0]   repeat_count;
  } search_cfg_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]  match_time;
    logic [COUNT_WIDTH-1:0] match_number;
    logic                   found;
    logic                   last;
  } result_t;

endpackage

### sv/waveform_pattern_trigger.sv
// waveform_pattern_trigger: pattern trigger for a logic analyser trace stream
// depends on wpt_pkg, wpt_lane, wpt_search, wpt_outq
//
// One trace sample (a time and four lane values) is taken per beat, one beat
// every clock cycle when the result side keeps up; a sample is fully judged
// in the cycle it is accepted, since the per-lane compares, the window check
// and the match counter update sit in one stage. Each sample gives at most
// two result beats (a match and, on the final sample, the closing result);
// these go into a four-entry result queue, so the sample side only stalls
// while that queue has fewer than two free entries. The result side sees the
// queue head, which holds steady while stalled. Configuration is written over
// the APB port at byte address 8*index, 64-bit data; write only while idle.
module waveform_pattern_trigger #(
  parameter int NUM_LANES  = wpt_pkg::DEF_NUM_LANES,
  parameter int MAX_REPEAT = wpt_pkg::DEF_MAX_REPEAT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // sample channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [wpt_pkg::TIME_WIDTH-1:0]     sample_time_i,
  input  logic [wpt_pkg::LANE_WIDTH-1:0]     lane0_value_i,
  input  logic [wpt_pkg::LANE_WIDTH-1:0]     lane1_value_i,
  input  logic [wpt_pkg::LANE_WIDTH-1:0]     lane2_value_i,
  input  logic [wpt_pkg::LANE_WIDTH-1:0]     lane3_value_i,
  input  logic                               first_of_trace_i,
  input  logic                               end_of_trace_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [wpt_pkg::TIME_WIDTH-1:0]     match_time_o,
  output logic [wpt_pkg::COUNT_WIDTH-1:0]    match_number_o,
  output logic                               found_o,
  output logic                               last_o,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wpt_pkg::ADDR_WIDTH-1:0]     paddr,
  input  logic [wpt_pkg::DATA_WIDTH-1:0]     pwdata,
  output logic [wpt_pkg::DATA_WIDTH-1:0]     prdata,
  output logic                               pready
);

  localparam int KW = wpt_pkg::KIND_WIDTH;
  localparam int LW = wpt_pkg::LANE_WIDTH;

  // configuration registers
  logic [KW*wpt_pkg::MAX_LANES-1:0]  kinds_q;
  logic [wpt_pkg::MAX_LANES-1:0]     enable_q;
  logic [LW*wpt_pkg::MAX_LANES-1:0]  values_q;
  logic [wpt_pkg::TIME_WIDTH-1:0]    win_start_q, win_end_q;
  logic [wpt_pkg::COUNT_WIDTH-1:0]   limit_q;
  logic [1:0]                        mode_q;
  logic [wpt_pkg::REP_WIDTH-1:0]     repeat_q;

  logic                              cfg_wr;
  wpt_pkg::reg_index_e               reg_idx;

  // lane state and verdicts
  logic [LW-1:0]        now_lane  [wpt_pkg::MAX_LANES];
  logic [LW-1:0]        prev_q    [NUM_LANES];
  logic [NUM_LANES-1:0] changed_v, ok_v;

  logic                 accept, room;
  logic                 res0_valid, res1_valid;
  wpt_pkg::result_t     res0, res1, head;
  wpt_pkg::search_cfg_t scfg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = wpt_pkg::reg_index_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kinds_q     <= '0;
      enable_q    <= '0;
      values_q    <= '0;
      win_start_q <= '0;
      win_end_q   <= '1;
      limit_q     <= '0;
      mode_q      <= wpt_pkg::MODE_COLLECT;
      repeat_q    <= wpt_pkg::REP_WIDTH'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        wpt_pkg::REG_LANE_KINDS:   kinds_q     <= pwdata[KW*wpt_pkg::MAX_LANES-1:0];
        wpt_pkg::REG_LANE_ENABLE:  enable_q    <= pwdata[wpt_pkg::MAX_LANES-1:0];
        wpt_pkg::REG_LANE_VALUES:  values_q    <= pwdata[LW*wpt_pkg::MAX_LANES-1:0];
        wpt_pkg::REG_WIN_START:    win_start_q <= pwdata[wpt_pkg::TIME_WIDTH-1:0];
        wpt_pkg::REG_WIN_END:      win_end_q   <= pwdata[wpt_pkg::TIME_WIDTH-1:0];
        wpt_pkg::REG_MATCH_LIMIT:  limit_q     <= pwdata[wpt_pkg::COUNT_WIDTH-1:0];
        wpt_pkg::REG_SEARCH_MODE:  mode_q      <= pwdata[1:0];
        wpt_pkg::REG_REPEAT_COUNT: repeat_q    <= pwdata[wpt_pkg::REP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      wpt_pkg::REG_LANE_KINDS:   prdata = wpt_pkg::DATA_WIDTH'(kinds_q);
      wpt_pkg::REG_LANE_ENABLE:  prdata = wpt_pkg::DATA_WIDTH'(enable_q);
      wpt_pkg::REG_LANE_VALUES:  prdata = wpt_pkg::DATA_WIDTH'(values_q);
      wpt_pkg::REG_WIN_START:    prdata = wpt_pkg::DATA_WIDTH'(win_start_q);
      wpt_pkg::REG_WIN_END:      prdata = wpt_pkg::DATA_WIDTH'(win_end_q);
      wpt_pkg::REG_MATCH_LIMIT:  prdata = wpt_pkg::DATA_WIDTH'(limit_q);
      wpt_pkg::REG_SEARCH_MODE:  prdata = wpt_pkg::DATA_WIDTH'(mode_q);
      wpt_pkg::REG_REPEAT_COUNT: prdata = wpt_pkg::DATA_WIDTH'(repeat_q);
      default:                   prdata = '0;
    endcase
  end

  // a sample beat is taken whenever the queue can absorb both possible results
  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  assign now_lane[0] = lane0_value_i;
  assign now_lane[1] = lane1_value_i;
  assign now_lane[2] = lane2_value_i;
  assign now_lane[3] = lane3_value_i;

  // one lane core per watched lane; on the first sample the previous value is the current one
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    logic [LW-1:0] prev_eff;

    assign prev_eff = first_of_trace_i ? now_lane[l] : prev_q[l];

    wpt_lane u_lane (
      .enable_i  (enable_q[l]),
      .kind_i    (kinds_q[KW*l +: KW]),
      .compare_i (values_q[LW*l +: LW]),
      .now_i     (now_lane[l]),
      .prev_i    (prev_eff),
      .changed_o (changed_v[l]),
      .ok_o      (ok_v[l])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        prev_q[l] <= '0;
      end else if (accept) begin
        prev_q[l] <= now_lane[l];
      end
    end
  end

  assign scfg = '{win_start: win_start_q, win_end: win_end_q, match_limit: limit_q,
                  mode: mode_q, repeat_count: repeat_q};

  // merge of the lane verdicts, counting and find logic
  wpt_search #(
    .MAX_REPEAT (MAX_REPEAT)
  ) u_search (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .first_i      (first_of_trace_i),
    .end_i        (end_of_trace_i),
    .any_enable_i (|enable_q[NUM_LANES-1:0]),
    .changed_i    (|changed_v),
    .lanes_ok_i   (&ok_v),
    .time_i       (sample_time_i),
    .cfg_i        (scfg),
    .res0_valid_o (res0_valid),
    .res0_o       (res0),
    .res1_valid_o (res1_valid),
    .res1_o       (res1)
  );

  // result queue parts the sample side from the result side
  wpt_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (accept && res0_valid),
    .data0_i (res0),
    .push1_i (accept && res1_valid),
    .data1_i (res1),
    .room_o  (room),
    .valid_o (out_valid_o),
    .data_o  (head),
    .pop_i   (!out_stall_i)
  );

  assign match_time_o   = head.match_time;
  assign match_number_o = head.match_number;
  assign found_o        = head.found;
  assign last_o         = head.last;

endmodule

### sv/wpt_lane.sv
// wpt_lane: one watched lane, change detect and criterion check
// depends on wpt_pkg
module wpt_lane (
  input  logic                            enable_i,
  input  logic [wpt_pkg::KIND_WIDTH-1:0]  kind_i,
  input  logic [wpt_pkg::LANE_WIDTH-1:0]  compare_i,
  input  logic [wpt_pkg::LANE_WIDTH-1:0]  now_i,
  input  logic [wpt_pkg::LANE_WIDTH-1:0]  prev_i,
  output logic                            changed_o,
  output logic                            ok_o
);

  localparam logic [wpt_pkg::LANE_WIDTH-1:0] ONE = wpt_pkg::LANE_WIDTH'(1);

  logic crit;

  always_comb begin
    unique case (wpt_pkg::lane_kind_e'(kind_i))
      wpt_pkg::KIND_HIGH:    crit = (now_i == ONE);
      wpt_pkg::KIND_LOW:     crit = (now_i == '0);
      wpt_pkg::KIND_VALUE:   crit = (now_i == compare_i);
      wpt_pkg::KIND_RISE:    crit = (prev_i != ONE) && (now_i == ONE);
      wpt_pkg::KIND_FALL:    crit = (prev_i == ONE) && (now_i != ONE);
      wpt_pkg::KIND_ANYEDGE: crit = (prev_i != now_i);
      default:               crit = 1'b1;
    endcase
  end

  assign changed_o = enable_i && (now_i != prev_i);
  assign ok_o      = !enable_i || crit;

endmodule

### sv/wpt_search.sv
// wpt_search: merges lane verdicts, keeps match count, ring and search state
// depends on wpt_pkg
module wpt_search #(
  parameter int MAX_REPEAT = wpt_pkg::DEF_MAX_REPEAT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic                             first_i,
  input  logic                             end_i,
  input  logic                             any_enable_i,
  input  logic                             changed_i,
  input  logic                             lanes_ok_i,
  input  logic [wpt_pkg::TIME_WIDTH-1:0]   time_i,
  input  wpt_pkg::search_cfg_t             cfg_i,
  output logic                             res0_valid_o,
  output wpt_pkg::result_t                 res0_o,
  output logic                             res1_valid_o,
  output wpt_pkg::result_t                 res1_o
);

  localparam int PW  = (MAX_REPEAT > 1) ? $clog2(MAX_REPEAT) : 1;
  localparam int RW0 = $clog2(MAX_REPEAT + 1);
  localparam int RW  = (RW0 > wpt_pkg::REP_WIDTH) ? RW0 : wpt_pkg::REP_WIDTH;
  localparam logic [RW-1:0]  REP_MAX  = RW'(MAX_REPEAT);
  localparam logic [PW-1:0]  PTR_LAST = PW'(MAX_REPEAT - 1);
  localparam logic [RW:0]    RING_LEN = (RW + 1)'(MAX_REPEAT);

  logic [wpt_pkg::COUNT_WIDTH-1:0] seen_q, seen_d, seen_base;
  logic                            fin_q, fin_d, fin_base, fin_mid;
  logic [PW-1:0]                   ptr_q, ptr_d, ptr_base;
  logic [wpt_pkg::TIME_WIDTH-1:0]  ring_q [MAX_REPEAT];

  logic [RW-1:0]  rep_raw, rep;
  logic [RW:0]    idx_sum;
  logic [PW-1:0]  rd_idx;
  logic           in_window, hit, is_fwd, is_bwd, at_rep, stop, bwd_ok;
  logic [wpt_pkg::TIME_WIDTH-1:0] ring_rd;

  // effective repeat number: zero reads as one, saturates at ring depth
  always_comb begin
    rep_raw = RW'(cfg_i.repeat_count);
    if (rep_raw == '0) begin
      rep = RW'(1);
    end else if (rep_raw > REP_MAX) begin
      rep = REP_MAX;
    end else begin
      rep = rep_raw;
    end
  end

  assign in_window = (cfg_i.win_end >= cfg_i.win_start) && (time_i >= cfg_i.win_start)
                     && (time_i <= cfg_i.win_end);

  assign seen_base = first_i ? '0 : seen_q;
  assign fin_base  = first_i ? 1'b0 : fin_q;
  assign ptr_base  = first_i ? '0 : ptr_q;

  assign hit    = (changed_i || first_i) && lanes_ok_i && any_enable_i && in_window
                  && !fin_base;
  assign is_fwd = (cfg_i.mode == wpt_pkg::MODE_FORWARD);
  assign is_bwd = (cfg_i.mode == wpt_pkg::MODE_BACKWARD);

  always_comb begin
    seen_d = seen_base;
    ptr_d  = ptr_base;
    if (hit) begin
      if (seen_base != wpt_pkg::COUNT_MAX) begin
        seen_d = seen_base + 1'b1;
      end
      ptr_d = (ptr_base == PTR_LAST) ? '0 : ptr_base + 1'b1;
    end
  end

  assign at_rep = (seen_d == wpt_pkg::COUNT_WIDTH'(rep));
  assign stop   = (cfg_i.match_limit != '0) && (seen_d >= cfg_i.match_limit);

  assign res0_valid_o = hit && (is_fwd ? at_rep : !is_bwd);
  assign res0_o = '{match_time: time_i, match_number: seen_d, found: 1'b1,
                    last: is_fwd ? 1'b1 : stop};

  assign fin_mid = fin_base || (hit && (is_fwd ? at_rep : (!is_bwd && stop)));

  // nth most recent match, with bypass for the slot written by this beat
  always_comb begin
    if ((RW + 1)'(ptr_d) >= (RW + 1)'(rep)) begin
      idx_sum = (RW + 1)'(ptr_d) - (RW + 1)'(rep);
    end else begin
      idx_sum = (RW + 1)'(ptr_d) + RING_LEN - (RW + 1)'(rep);
    end
    rd_idx  = idx_sum[PW-1:0];
    ring_rd = (hit && (rd_idx == ptr_base)) ? time_i : ring_q[rd_idx];
  end

  assign bwd_ok       = is_bwd && (seen_d >= wpt_pkg::COUNT_WIDTH'(rep));
  assign res1_valid_o = end_i && !fin_mid;
  assign res1_o = '{match_time: bwd_ok ? ring_rd : '0, match_number: seen_d,
                    found: bwd_ok, last: 1'b1};

  assign fin_d = fin_mid || end_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      fin_q  <= 1'b0;
      ptr_q  <= '0;
    end else if (accept_i) begin
      seen_q <= seen_d;
      fin_q  <= fin_d;
      ptr_q  <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && hit) begin
      ring_q[ptr_base] <= time_i;
    end
  end

endmodule

### sv/wpt_outq.sv
// wpt_outq: small result queue, up to two pushes and one pop per cycle
// depends on wpt_pkg
module wpt_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push0_i,
  input  wpt_pkg::result_t data0_i,
  input  logic             push1_i,
  input  wpt_pkg::result_t data1_i,
  output logic             room_o,
  output logic             valid_o,
  output wpt_pkg::result_t data_o,
  input  logic             pop_i
);

  localparam int PW = $clog2(wpt_pkg::OUTQ_DEPTH);
  localparam int CW = $clog2(wpt_pkg::OUTQ_DEPTH + 1);
  localparam logic [CW-1:0] ROOM_LIMIT = CW'(wpt_pkg::OUTQ_DEPTH - 2);

  wpt_pkg::result_t mem_q [wpt_pkg::OUTQ_DEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_pop;
  logic [1:0]    n_push;
  wpt_pkg::result_t first_data;

  assign valid_o    = (cnt_q != '0);
  assign data_o     = mem_q[rp_q];
  assign room_o     = (cnt_q <= ROOM_LIMIT);
  assign do_pop     = pop_i && valid_o;
  assign n_push     = {1'b0, push0_i} + {1'b0, push1_i};
  assign first_data = push0_i ? data0_i : data1_i;

  assign wp_d  = wp_q + PW'(n_push);
  assign rp_d  = rp_q + PW'(do_pop);
  assign cnt_d = cnt_q + CW'(n_push) - CW'(do_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wp_q] <= first_data;
    end
    if (push0_i && push1_i) begin
      mem_q[wp_q + 1'b1] <= data1_i;
    end
  end

endmodule

### sim/waveform_pattern_trigger_test.sv
`timescale 1ns / 1ps
// waveform_pattern_trigger_test: self-checking bench for the pattern trigger
// drives trace samples and APB register writes, predicts every result beat
// from its own model of the trigger; depends on wpt_pkg and the block's rtl
module waveform_pattern_trigger_test;
  import wpt_pkg::*;

  localparam int LANES         = DEF_NUM_LANES;
  localparam int RING_DEPTH    = DEF_MAX_REPEAT;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_SAMPLES = 36;
  localparam int MAX_PRINTED   = 40;

  // codes the package leaves unnamed: both are legal register contents
  localparam logic [KIND_WIDTH-1:0] KIND_SPARE = 3'd7;  // judged as don't care
  localparam logic [1:0]            MODE_SPARE = 2'd3;  // judged as collect

  typedef struct packed {
    logic [TIME_WIDTH-1:0]             stamp;
    logic [3:0][LANE_WIDTH-1:0]        lanes;
    logic                              first;
    logic                              closing;
  } trace_sample_t;

  // clock, reset and block ports
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [TIME_WIDTH-1:0]  sample_time_i = '0;
  logic [LANE_WIDTH-1:0]  lane0_value_i = '0;
  logic [LANE_WIDTH-1:0]  lane1_value_i = '0;
  logic [LANE_WIDTH-1:0]  lane2_value_i = '0;
  logic [LANE_WIDTH-1:0]  lane3_value_i = '0;
  logic                   first_of_trace_i = 1'b0;
  logic                   end_of_trace_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [TIME_WIDTH-1:0]  match_time_o;
  logic [COUNT_WIDTH-1:0] match_number_o;
  logic                   found_o;
  logic                   last_o;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0]  paddr = '0;
  logic [DATA_WIDTH-1:0]  pwdata = '0;
  logic [DATA_WIDTH-1:0]  prdata;
  logic                   pready;

  // bench control
  logic        steady_flow = 1'b0;   // no idling on either side while set, but a hold still wins
  logic        hold_active = 1'b0;   // long result-side hold-off
  event        hold_trigger;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned samples_sent = 0;
  int unsigned results_checked = 0;

  // register mirror, reset values as the block comes out of reset
  logic [3*LANES-1:0]      lane_kinds_q = '0;
  logic [LANES-1:0]        lane_enable_q = '0;
  logic [DATA_WIDTH-1:0]   lane_values_q = '0;
  logic [TIME_WIDTH-1:0]   win_start_q = '0;
  logic [TIME_WIDTH-1:0]   win_end_q = '1;
  logic [COUNT_WIDTH-1:0]  match_limit_q = '0;
  logic [1:0]              search_mode_q = MODE_COLLECT;
  logic [REP_WIDTH-1:0]    repeat_q = 5'd1;

  // trigger state as the predictor sees it
  logic [3:0][LANE_WIDTH-1:0] prev_lanes = '0;
  logic [COUNT_WIDTH-1:0]     matches_seen = '0;
  logic                       search_done = 1'b0;
  logic [TIME_WIDTH-1:0]      recent_times [RING_DEPTH];
  int                         ring_ptr = 0;

  // result beats still owed by the block, oldest first
  result_t awaited_results [$];

  waveform_pattern_trigger uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_time_i  (sample_time_i),
    .lane0_value_i  (lane0_value_i),
    .lane1_value_i  (lane1_value_i),
    .lane2_value_i  (lane2_value_i),
    .lane3_value_i  (lane3_value_i),
    .first_of_trace_i (first_of_trace_i),
    .end_of_trace_i (end_of_trace_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .match_time_o   (match_time_o),
    .match_number_o (match_number_o),
    .found_o        (found_o),
    .last_o         (last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit, well beyond the slowest correct run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d result beats outstanding", cycle_count,
               awaited_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls, none during a steady stretch, solid during a hold
  always @(posedge clk_i) begin
    if (hold_active)
      out_stall_i <= 1'b1;
    else if (steady_flow)
      out_stall_i <= 1'b0;
    else
      out_stall_i <= ($urandom_range(99) < 14);
  end

  // long hold-off, counted here so the sender keeps offering samples meanwhile
  initial begin
    forever begin
      @(hold_trigger);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_active <= 1'b0;
    end
  end

  task automatic note_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // result checker: every accepted beat against the oldest prediction
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (awaited_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result beat, time %0h number %0d",
                                match_time_o, match_number_o));
      end else begin
        want = awaited_results.pop_front();
        if (match_time_o !== want.match_time)
          note_mismatch($sformatf("match_time %0h, predicted %0h", match_time_o,
                                  want.match_time));
        if (match_number_o !== want.match_number)
          note_mismatch($sformatf("match_number %0d, predicted %0d", match_number_o,
                                  want.match_number));
        if (found_o !== want.found)
          note_mismatch($sformatf("found %b, predicted %b", found_o, want.found));
        if (last_o !== want.last)
          note_mismatch($sformatf("last %b, predicted %b", last_o, want.last));
      end
    end
  end

  function automatic logic lane_meets(input logic [KIND_WIDTH-1:0] kind,
                                      input logic [LANE_WIDTH-1:0] now,
                                      input logic [LANE_WIDTH-1:0] prior,
                                      input logic [LANE_WIDTH-1:0] target);
    case (kind)
      KIND_HIGH:    return now == 16'd1;
      KIND_LOW:     return now == 16'd0;
      KIND_VALUE:   return now == target;
      KIND_RISE:    return prior != 16'd1 && now == 16'd1;
      KIND_FALL:    return prior == 16'd1 && now != 16'd1;
      KIND_ANYEDGE: return prior != now;
      default:      return 1'b1;  // don't care and the spare code
    endcase
  endfunction

  task automatic queue_result(input logic [TIME_WIDTH-1:0] stamp, input logic hit,
                              input logic final_beat);
    result_t r;
    r.match_time   = stamp;
    r.match_number = matches_seen;
    r.found        = hit;
    r.last         = final_beat;
    awaited_results = {awaited_results, r};
  endtask

  // predictor: judges one accepted sample and queues the beats it causes
  task automatic judge_sample(input trace_sample_t s);
    logic changed;
    logic ok;
    logic stop;
    int   rep;
    int   i;
    changed = s.first;
    ok      = (lane_enable_q != '0);
    rep     = (repeat_q == '0) ? 1 : int'(repeat_q);
    if (rep > RING_DEPTH) rep = RING_DEPTH;
    // a new trace restarts the search and has no previous values of its own
    if (s.first) begin
      prev_lanes   = s.lanes;
      matches_seen = '0;
      search_done  = 1'b0;
      ring_ptr     = 0;
    end
    for (i = 0; i < LANES; i++) begin
      if (lane_enable_q[i]) begin
        if (s.lanes[i] != prev_lanes[i]) changed = 1'b1;
        if (!lane_meets(lane_kinds_q[3*i +: 3], s.lanes[i], prev_lanes[i],
                        lane_values_q[16*i +: 16]))
          ok = 1'b0;
      end
    end
    if (win_end_q < win_start_q || s.stamp < win_start_q || s.stamp > win_end_q) ok = 1'b0;

    if (changed && ok && !search_done) begin
      if (matches_seen != COUNT_MAX) matches_seen++;
      recent_times[ring_ptr] = s.stamp;
      ring_ptr = (ring_ptr + 1) % RING_DEPTH;
      if (search_mode_q == MODE_FORWARD) begin
        if (int'(matches_seen) == rep) begin
          queue_result(s.stamp, 1'b1, 1'b1);
          search_done = 1'b1;
        end
      end else if (search_mode_q != MODE_BACKWARD) begin
        stop = (match_limit_q != '0) && (matches_seen >= match_limit_q);
        queue_result(s.stamp, 1'b1, stop);
        if (stop) search_done = 1'b1;
      end
    end

    // closing beat of an unfinished search follows any match beat
    if (s.closing && !search_done) begin
      if (search_mode_q == MODE_BACKWARD && int'(matches_seen) >= rep)
        queue_result(recent_times[(ring_ptr + RING_DEPTH - rep) % RING_DEPTH], 1'b1, 1'b1);
      else
        queue_result('0, 1'b0, 1'b1);
      search_done = 1'b1;
    end
    prev_lanes = s.lanes;
  endtask

  // one register write: setup cycle, then access cycle until pready, then a
  // cycle with the port idle
  task automatic write_reg(input reg_index_e idx, input logic [DATA_WIDTH-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WIDTH'(int'(idx) * 8);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LANE_KINDS:   lane_kinds_q  = value[3*LANES-1:0];
      REG_LANE_ENABLE:  lane_enable_q = value[LANES-1:0];
      REG_LANE_VALUES:  lane_values_q = value;
      REG_WIN_START:    win_start_q   = value[TIME_WIDTH-1:0];
      REG_WIN_END:      win_end_q     = value[TIME_WIDTH-1:0];
      REG_MATCH_LIMIT:  match_limit_q = value[COUNT_WIDTH-1:0];
      REG_SEARCH_MODE:  search_mode_q = value[1:0];
      REG_REPEAT_COUNT: repeat_q      = value[REP_WIDTH-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // offers one sample beat, holding it until taken; valid is left high so
  // back-to-back beats need no second assignment in the same step
  task automatic drive_sample(input trace_sample_t s);
    if (!steady_flow) begin
      while ($urandom_range(99) < 14) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i       <= 1'b1;
    sample_time_i    <= s.stamp;
    lane0_value_i    <= s.lanes[0];
    lane1_value_i    <= s.lanes[1];
    lane2_value_i    <= s.lanes[2];
    lane3_value_i    <= s.lanes[3];
    first_of_trace_i <= s.first;
    end_of_trace_i   <= s.closing;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    judge_sample(s);
    samples_sent++;
  endtask

  task automatic send_lanes(input logic [TIME_WIDTH-1:0] stamp,
                            input logic [LANE_WIDTH-1:0] l0, input logic [LANE_WIDTH-1:0] l1,
                            input logic [LANE_WIDTH-1:0] l2, input logic [LANE_WIDTH-1:0] l3,
                            input logic first, input logic closing);
    trace_sample_t s;
    s.stamp    = stamp;
    s.lanes[0] = l0;
    s.lanes[1] = l1;
    s.lanes[2] = l2;
    s.lanes[3] = l3;
    s.first    = first;
    s.closing  = closing;
    drive_sample(s);
  endtask

  // lane 0 follows the low time bit, so it toggles every beat even across
  // a split trace; the other lanes carry noise
  task automatic toggle_trace(input logic [TIME_WIDTH-1:0] base, input int count,
                              input logic with_first, input logic with_end);
    logic [TIME_WIDTH-1:0] stamp;
    int k;
    for (k = 0; k < count; k++) begin
      stamp = base + TIME_WIDTH'(k);
      send_lanes(stamp, LANE_WIDTH'(stamp[0]), 16'($urandom), 16'($urandom),
                 16'($urandom), with_first && k == 0, with_end && k == count - 1);
    end
  endtask

  // lets the block go quiet: input idle, every owed beat in, then a margin
  task automatic settle_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [TIME_WIDTH-1:0] first_t,
                            input logic [TIME_WIDTH-1:0] last_t);
    write_reg(REG_WIN_START, DATA_WIDTH'(first_t));
    write_reg(REG_WIN_END, DATA_WIDTH'(last_t));
  endtask

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // reset settings: no lane enabled, so a trace only gets its closing beat;
  // also the top of every field range
  task automatic test_reset_defaults();
    send_lanes('1, '1, '1, '1, '1, 1'b1, 1'b0);
    send_lanes('0, '0, '0, '0, '0, 1'b0, 1'b1);
    settle_block();
  endtask

  // every lane criterion, the spare kind code and a partial lane enable
  task automatic test_lane_criteria();
    write_reg(REG_LANE_KINDS, DATA_WIDTH'({KIND_SPARE, KIND_VALUE, KIND_LOW, KIND_HIGH}));
    write_reg(REG_LANE_ENABLE, DATA_WIDTH'(4'hF));
    write_reg(REG_LANE_VALUES, {16'h1234, 16'hA5A5, 16'h0000, 16'h0000});
    send_lanes(100, 16'd1, 16'd0, 16'hA5A5, 16'h0000, 1'b1, 1'b0);
    send_lanes(101, 16'd1, 16'd0, 16'hA5A5, 16'hFFFF, 1'b0, 1'b0);
    send_lanes(102, 16'd1, 16'd1, 16'hA5A5, 16'hFFFF, 1'b0, 1'b1);
    settle_block();

    write_reg(REG_LANE_KINDS,
              DATA_WIDTH'({KIND_DONTCARE, KIND_ANYEDGE, KIND_FALL, KIND_RISE}));
    write_reg(REG_LANE_ENABLE, DATA_WIDTH'(4'b0111));
    send_lanes(200, 16'd0, 16'd1, 16'd5, 16'd0, 1'b1, 1'b0);
    send_lanes(201, 16'd1, 16'd0, 16'd6, 16'd9, 1'b0, 1'b0);
    send_lanes(202, 16'd1, 16'd0, 16'd6, 16'd9, 1'b0, 1'b0);
    send_lanes(203, 16'd2, 16'd0, 16'd7, 16'd9, 1'b0, 1'b1);
    settle_block();
  endtask

  // forward with repeat zero, backward, the spare mode with a match limit,
  // and a repeat number above the ring depth
  task automatic test_search_modes();
    write_reg(REG_LANE_KINDS, DATA_WIDTH'(KIND_ANYEDGE));
    write_reg(REG_LANE_ENABLE, DATA_WIDTH'(4'b0001));
    write_reg(REG_SEARCH_MODE, DATA_WIDTH'(MODE_FORWARD));
    write_reg(REG_REPEAT_COUNT, '0);
    toggle_trace(300, 3, 1'b1, 1'b1);
    settle_block();

    write_reg(REG_SEARCH_MODE, DATA_WIDTH'(MODE_BACKWARD));
    write_reg(REG_REPEAT_COUNT, DATA_WIDTH'(2));
    toggle_trace(400, 4, 1'b1, 1'b1);
    settle_block();

    write_reg(REG_SEARCH_MODE, DATA_WIDTH'(MODE_SPARE));
    write_reg(REG_MATCH_LIMIT, DATA_WIDTH'(2));
    toggle_trace(500, 4, 1'b1, 1'b1);
    settle_block();

    write_reg(REG_SEARCH_MODE, DATA_WIDTH'(MODE_BACKWARD));
    write_reg(REG_REPEAT_COUNT, DATA_WIDTH'({REP_WIDTH{1'b1}}));
    toggle_trace(600, 2, 1'b1, 1'b1);
    settle_block();
  endtask

  // one-point window at the top of time, then an empty window
  task automatic test_window_edges();
    write_reg(REG_LANE_KINDS, DATA_WIDTH'(KIND_DONTCARE));
    write_reg(REG_SEARCH_MODE, DATA_WIDTH'(MODE_COLLECT));
    write_reg(REG_MATCH_LIMIT, '0);
    set_window('1, '1);
    toggle_trace(32'hFFFF_FFFE, 2, 1'b1, 1'b1);
    settle_block();

    set_window(200, 100);
    toggle_trace(150, 2, 1'b1, 1'b1);
    settle_block();
  endtask

  // result side held off while samples keep coming, so the result queue
  // fills and the sample side stalls; then a mid-trace pause until drained
  task automatic test_result_backpressure();
    write_reg(REG_LANE_KINDS, DATA_WIDTH'(KIND_DONTCARE));
    write_reg(REG_REPEAT_COUNT, DATA_WIDTH'(1));
    set_window('0, '1);
    steady_flow <= 1'b1;
    -> hold_trigger;
    toggle_trace(1000, 40, 1'b1, 1'b0);
    settle_block();
    toggle_trace(1040, 20, 1'b0, 1'b1);
    steady_flow <= 1'b0;
    settle_block();
  endtask

  // ---------------------------------------------------------------------------
  // random phases
  // ---------------------------------------------------------------------------

  function automatic logic [LANE_WIDTH-1:0] pick_lane(input int lane,
                                                      input logic [LANE_WIDTH-1:0] prior);
    case ($urandom_range(9))
      0, 1, 2: return prior;
      3, 4:    return 16'd0;
      5, 6:    return 16'd1;
      7:       return lane_values_q[16*lane +: 16];
      default: return 16'($urandom);
    endcase
  endfunction

  // fresh settings for a phase; the window is placed around the phase's times
  task automatic random_settings(input logic [TIME_WIDTH-1:0] base);
    logic [3*LANES-1:0]    kinds;
    logic [DATA_WIDTH-1:0] values;
    logic [TIME_WIDTH-1:0] ws;
    logic [TIME_WIDTH-1:0] we;
    int i;
    for (i = 0; i < LANES; i++) begin
      kinds[3*i +: 3] = 3'($urandom_range(7));
      case ($urandom_range(2))
        0:       values[16*i +: 16] = 16'd0;
        1:       values[16*i +: 16] = 16'd1;
        default: values[16*i +: 16] = 16'($urandom);
      endcase
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin ws = '0; we = '1; end
      5, 6, 7: begin
        ws = base + $urandom_range(30);
        we = ws + $urandom_range(40);
      end
      8: begin ws = base + 40; we = base + 10; end  // empty window
      default: begin ws = base + $urandom_range(20); we = ws; end
    endcase
    write_reg(REG_LANE_KINDS, DATA_WIDTH'(kinds));
    // mostly a single lane, so matches stay common
    write_reg(REG_LANE_ENABLE, $urandom_range(1) ? DATA_WIDTH'(1 << $urandom_range(3))
                                                 : DATA_WIDTH'($urandom_range(15)));
    write_reg(REG_LANE_VALUES, values);
    set_window(ws, we);
    write_reg(REG_MATCH_LIMIT, ($urandom_range(9) == 0) ? DATA_WIDTH'(COUNT_MAX)
                                                        : DATA_WIDTH'($urandom_range(3)));
    write_reg(REG_SEARCH_MODE, DATA_WIDTH'($urandom_range(3)));
    write_reg(REG_REPEAT_COUNT, ($urandom_range(4) == 0) ? DATA_WIDTH'($urandom_range(31))
                                                         : DATA_WIDTH'($urandom_range(4)));
  endtask

  // mostly well-formed traces (start flag first, end flag last); the rest
  // carry flags at random and the odd stray time
  task automatic random_trace(inout logic [TIME_WIDTH-1:0] stamp, output int count);
    trace_sample_t s;
    logic [3:0][LANE_WIDTH-1:0] held;
    logic broken;
    int k;
    int i;
    broken = ($urandom_range(99) < 15);
    count  = $urandom_range(1, 12);
    held   = prev_lanes;
    for (k = 0; k < count; k++) begin
      s.stamp = stamp;
      stamp++;
      if (broken && $urandom_range(9) == 0) s.stamp = $urandom;
      for (i = 0; i < LANES; i++) s.lanes[i] = pick_lane(i, held[i]);
      held      = s.lanes;
      s.first   = broken ? ($urandom_range(9) == 0) : (k == 0);
      s.closing = broken ? ($urandom_range(4) == 0) : (k == count - 1);
      drive_sample(s);
    end
  endtask

  task automatic test_random_phases();
    logic [TIME_WIDTH-1:0] stamp;
    int phase;
    int sent;
    int count;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      stamp = $urandom_range(32'hFFFF_FF00);
      random_settings(stamp);
      // one phase with no idling at all on either side
      steady_flow <= (phase == 3);
      sent = 0;
      while (sent < PHASE_SAMPLES) begin
        random_trace(stamp, count);
        sent += count;
      end
      steady_flow <= 1'b0;
      settle_block();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_defaults();
    test_lane_criteria();
    test_search_modes();
    test_window_edges();
    test_result_backpressure();
    test_random_phases();

    settle_block();
    $display("covered %0d trace samples and %0d result beats: all lane kinds, all search",
             samples_sent, results_checked);
    $display("modes, window edges, result hold-off and random traces");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
